FILE: hdl/matrix_torus_shift_core_defines.svh
// assertion macros shared by the matrix torus shift design
`ifndef MATRIX_TORUS_SHIFT_CORE_DEFINES_SVH
`define MATRIX_TORUS_SHIFT_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define MTS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mts_pkg.sv
// shared types and constants of the matrix torus shift design
package mts_pkg;

    localparam int MAX_DIM_DEF    = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W       = 2;
    localparam int ROW_W      = 4;
    localparam int VAL_W      = 32;
    localparam int SIZE_W     = 5;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_SHIFT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_COUNT = 2'd1;

    localparam logic [SIZE_W-1:0]  MATRIX_SIZE_RST = 5'd16;
    localparam logic [COUNT_W-1:0] SHIFT_COUNT_RST = 16'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_SWEEP,
        ST_DRAIN
    } mts_state_t;

    // status from the shift sequencer to the datapath
    typedef struct packed {
        logic busy;
        logic wr_en;
        logic flip;
    } mts_sweep_t;

endpackage

FILE: hdl/mts_ram.sv
// generic simple dual-port ram with registered read
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/mts_mod.sv
// bit-serial remainder unit: shift count modulo matrix size
module mts_mod #(
    parameter int MAX_DIM = mts_pkg::MAX_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [mts_pkg::COUNT_W-1:0]       dividend,
    input  logic [$clog2(MAX_DIM+1)-1:0]      divisor,
    output logic                              done,
    output logic [$clog2(MAX_DIM+1)-1:0]      rem
);
    import mts_pkg::*;

    localparam int N_W   = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(COUNT_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COUNT_W-1:0] quo_reg, quo_next;
    logic [N_W-1:0]     rem_reg, rem_next;
    logic [N_W:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, quo_reg[COUNT_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(COUNT_W);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // one restoring step; remainder stays below divisor
            if (trial >= {1'b0, divisor})
            begin
                rem_next = N_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = N_W'(trial);
            end
            quo_next = {quo_reg[COUNT_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: hdl/mts_shift_ctrl.sv
// shift sequencer: remainder, then a copy sweep between the two banks if it is nonzero
module mts_shift_ctrl #(
    parameter int MAX_DIM = mts_pkg::MAX_DIM_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  shift_go,
    input  logic [$clog2(MAX_DIM+1)-1:0]          n,
    input  logic [mts_pkg::COUNT_W-1:0]           shift_count,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    src_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    dst_addr,
    output mts_pkg::mts_sweep_t                   status
);
    import mts_pkg::*;

    localparam int N_W   = $clog2(MAX_DIM + 1);
    localparam int SW    = N_W + 1;
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int AW    = $clog2(MAX_DIM * MAX_DIM);

    mts_state_t       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic             wr_en_reg, wr_en_next;
    logic [AW-1:0]    dst_reg, dst_next;

    logic             mod_start;
    logic             mod_done;
    logic [N_W-1:0]   k;

    logic             in_block;
    logic             last_j;
    logic [SW-1:0]    si_sum, sj_sum, src_i, src_j;

    mts_mod #(
        .MAX_DIM (MAX_DIM)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (shift_count),
        .divisor  (n),
        .done     (mod_done),
        .rem      (k)
    );

    // source of entry (i, j): old[(i+k) mod n][(j-k) mod n] inside the block
    always_comb
    begin
        in_block = (SW'(i_reg) < SW'(n)) && (SW'(j_reg) < SW'(n));
        si_sum   = SW'(i_reg) + SW'(k);
        sj_sum   = SW'(j_reg) + SW'(n) - SW'(k);
        if (si_sum >= SW'(n))
        begin
            si_sum = si_sum - SW'(n);
        end
        if (sj_sum >= SW'(n))
        begin
            sj_sum = sj_sum - SW'(n);
        end
        src_i    = in_block ? si_sum : SW'(i_reg);
        src_j    = in_block ? sj_sum : SW'(j_reg);
        src_addr = AW'(src_i * MAX_DIM + src_j);
        last_j   = (j_reg == IDX_W'(MAX_DIM - 1));
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        wr_en_next = 1'b0;
        dst_next   = dst_reg;
        mod_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (shift_go && (n != '0))
                begin
                    mod_start  = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = (k == '0) ? ST_IDLE : ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                wr_en_next = 1'b1;
                dst_next   = AW'(i_reg * MAX_DIM + j_reg);
                j_next     = last_j ? '0 : j_reg + 1'b1;
                if (last_j)
                begin
                    i_next = i_reg + 1'b1;
                    if (i_reg == IDX_W'(MAX_DIM - 1))
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wr_en_reg <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wr_en_reg <= wr_en_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg <= dst_next;
    end

    assign dst_addr      = dst_reg;
    assign status.busy   = (state_reg != ST_IDLE);
    assign status.wr_en  = wr_en_reg;
    assign status.flip   = (state_reg == ST_DRAIN);

endmodule

FILE: hdl/matrix_torus_shift_core.sv
// Square matrix store with cyclic row and column rotation. Writes and reads
// are accepted while busy is low, and one may then be started every cycle; a
// read returns its item on read_value with read_valid in the cycle after it is
// accepted, and the receiver cannot stall it. A shift first runs a bit-serial
// remainder of shift_count by the matrix size, then copies all MAX_DIM*MAX_DIM
// entries from the live bank into the spare bank, one ram read and one write
// per cycle, and swaps the banks, with busy high throughout (no copy when the
// rotation amount is zero, and busy stays low for a zero size).
// Configuration writes are always ready and are meant for idle periods.
module matrix_torus_shift_core #(
    parameter int MAX_DIM    = mts_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [mts_pkg::OP_W-1:0]           op,
    input  logic [mts_pkg::ROW_W-1:0]          row,
    input  logic [mts_pkg::ROW_W-1:0]          col,
    input  logic signed [mts_pkg::VAL_W-1:0]   value,
    output logic                               read_valid,
    output logic signed [mts_pkg::VAL_W-1:0]   read_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mts_pkg::*;

    `include "matrix_torus_shift_core_defines.svh"

    localparam int N_W   = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [SIZE_W-1:0]     matrix_size_reg, matrix_size_next;
    logic [COUNT_W-1:0]    shift_count_reg, shift_count_next;
    logic                  bank_reg, bank_next;
    logic                  read_valid_reg, read_valid_next;
    logic                  in_range_reg, in_range_next;

    logic [N_W-1:0]        n;
    logic                  accept;
    logic                  in_range;
    logic                  item_wr;
    logic [AW-1:0]         item_addr;
    logic [AW-1:0]         src_addr, dst_addr;
    mts_sweep_t            sweep;

    logic [AW-1:0]         raddr, waddr;
    logic [DATA_WIDTH-1:0] wdata, rdata0, rdata1, rdata_cur;
    logic                  we0, we1;

    always_comb
    begin
        if (32'(matrix_size_reg) > MAX_DIM)
        begin
            n = N_W'(MAX_DIM);
        end
        else
        begin
            n = N_W'(matrix_size_reg);
        end
    end

    assign busy      = sweep.busy;
    assign accept    = start && !sweep.busy;
    assign in_range  = (32'(row) < 32'(n)) && (32'(col) < 32'(n));
    assign item_addr = AW'(row * MAX_DIM + col);
    assign item_wr   = accept && (op == OP_WRITE) && in_range;

    mts_shift_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift_go    (accept && (op == OP_SHIFT)),
        .n           (n),
        .shift_count (shift_count_reg),
        .src_addr    (src_addr),
        .dst_addr    (dst_addr),
        .status      (sweep)
    );

    // live bank is bank_reg; a sweep reads it and fills the other one
    assign rdata_cur = bank_reg ? rdata1 : rdata0;
    assign raddr     = sweep.busy ? src_addr : item_addr;
    assign waddr     = sweep.wr_en ? dst_addr : item_addr;
    assign wdata     = sweep.wr_en ? rdata_cur : DATA_WIDTH'(value);
    assign we0       = (item_wr && !bank_reg) || (sweep.wr_en && bank_reg);
    assign we1       = (item_wr && bank_reg) || (sweep.wr_en && !bank_reg);

    mts_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata0)
    );

    mts_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata1)
    );

    always_comb
    begin
        matrix_size_next = matrix_size_reg;
        shift_count_next = shift_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MATRIX_SIZE: matrix_size_next = cfg_data[SIZE_W-1:0];
                CFG_SHIFT_COUNT: shift_count_next = cfg_data[COUNT_W-1:0];
                default:         matrix_size_next = matrix_size_reg;
            endcase
        end
        bank_next       = sweep.flip ? !bank_reg : bank_reg;
        read_valid_next = accept && (op == OP_READ);
        in_range_next   = in_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg <= MATRIX_SIZE_RST;
            shift_count_reg <= SHIFT_COUNT_RST;
            bank_reg        <= 1'b0;
            read_valid_reg  <= 1'b0;
            in_range_reg    <= 1'b0;
        end
        else
        begin
            matrix_size_reg <= matrix_size_next;
            shift_count_reg <= shift_count_next;
            bank_reg        <= bank_next;
            read_valid_reg  <= read_valid_next;
            in_range_reg    <= in_range_next;
        end
    end

    assign cfg_ready  = 1'b1;
    assign read_valid = read_valid_reg;
    // out-of-range reads answer zero; stored words are sign-extended
    assign read_value = in_range_reg ? VAL_W'(signed'(rdata_cur)) : '0;

    `MTS_ASSERT_NEXT(a_read_strobe, accept && (op == OP_READ), read_valid, "read item lost")
    `MTS_ASSERT_IMPLY(a_strobe_idle, read_valid, !sweep.busy, "result during shift")
    `MTS_ASSERT_IMPLY(a_sweep_wr_busy, sweep.wr_en, sweep.busy, "copy write outside sweep")
    `MTS_ASSERT_NEXT(a_flip_idle, sweep.flip, !sweep.busy && (bank_reg != $past(bank_reg)),
        "bank swap did not end the shift")

endmodule

FILE: tb/sv/tb.sv
// testbench for the matrix torus shift core: scoreboard class, command and setting drivers
`timescale 1ns / 1ps

module tb;
    import mts_pkg::*;

    localparam int DIM          = MAX_DIM_DEF;
    localparam int RESET_CYCLES = 11;
    localparam int PHASES       = 16;
    localparam int PHASE_ITEMS  = 125;
    // a shift keeps the core busy through its copy sweep and gives no item
    localparam int DRAIN_CYCLES = DIM * DIM + 40;
    localparam int STALL_LIMIT  = 8 * DRAIN_CYCLES;

    localparam logic [OP_W-1:0]      OP_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    class torus_scoreboard;
        logic signed [VAL_W-1:0] cells [DIM][DIM];
        bit                      filled [DIM][DIM];
        int unsigned             size_reg;
        int unsigned             count_reg;
        logic signed [VAL_W-1:0] pending_reads [$];
        int unsigned             mismatches;

        function new();
            size_reg   = MATRIX_SIZE_RST;
            count_reg  = SHIFT_COUNT_RST;
            mismatches = 0;
            foreach (cells[i, j])
            begin
                cells[i][j]  = '0;
                filled[i][j] = 1'b0;
            end
        endfunction

        function int unsigned span();
            return (size_reg > DIM) ? DIM : size_reg;
        endfunction

        function bit readable(int unsigned r, int unsigned c);
            return (r < span()) && (c < span()) && filled[r][c];
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MATRIX_SIZE: size_reg = data[SIZE_W-1:0];
                CFG_SHIFT_COUNT: count_reg = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // rows right by k, columns up by k, all in one pass
        function void rotate();
            logic signed [VAL_W-1:0] old_cells [DIM][DIM];
            bit                      old_filled [DIM][DIM];
            int unsigned             n;
            int unsigned             k;
            n = span();
            if (n == 0 || count_reg == 0)
                return;
            k = count_reg % n;
            if (k == 0)
                return;
            old_cells  = cells;
            old_filled = filled;
            for (int unsigned i = 0; i < n; i++)
            begin
                for (int unsigned j = 0; j < n; j++)
                begin
                    cells[i][j]  = old_cells[(i + k) % n][(j + n - k) % n];
                    filled[i][j] = old_filled[(i + k) % n][(j + n - k) % n];
                end
            end
        endfunction

        function void note_command(logic [OP_W-1:0] kind, logic [ROW_W-1:0] r,
                                   logic [ROW_W-1:0] c, logic signed [VAL_W-1:0] v);
            bit hit;
            hit = (r < span()) && (c < span());
            case (kind)
                OP_WRITE:
                begin
                    if (hit)
                    begin
                        cells[r][c]  = v;
                        filled[r][c] = 1'b1;
                    end
                end
                OP_SHIFT: rotate();
                OP_READ: pending_reads.push_back(hit ? cells[r][c] : '0);
                default: ;
            endcase
        endfunction

        function void check_read(logic signed [VAL_W-1:0] got);
            logic signed [VAL_W-1:0] want;
            if (pending_reads.size() == 0)
            begin
                $error("read_value: no item expected, actual %0d", got);
                mismatches++;
                return;
            end
            want = pending_reads.pop_front();
            if (got !== want)
            begin
                $error("read_value: expected %0d, actual %0d", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    start     = 1'b0;
    logic                    busy;
    logic [OP_W-1:0]         op        = OP_WRITE;
    logic [ROW_W-1:0]        row       = '0;
    logic [ROW_W-1:0]        col       = '0;
    logic signed [VAL_W-1:0] value     = '0;
    logic                    read_valid;
    logic signed [VAL_W-1:0] read_value;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = CFG_MATRIX_SIZE;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    torus_scoreboard board;
    int unsigned     stalled = 0;

    matrix_torus_shift_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .row        (row),
        .col        (col),
        .value      (value),
        .read_valid (read_valid),
        .read_value (read_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && read_valid === 1'b1)
            board.check_read(read_value);
    end

    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || (cfg_valid && cfg_ready === 1'b1) || read_valid === 1'b1)
            stalled <= 0;
        else
        begin
            stalled <= stalled + 1;
            if (stalled >= STALL_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // start is left high so back-to-back items need no extra assignment
    task automatic issue(input logic [OP_W-1:0] kind, input logic [ROW_W-1:0] r,
                         input logic [ROW_W-1:0] c, input logic signed [VAL_W-1:0] v);
        start <= 1'b1;
        op    <= kind;
        row   <= r;
        col   <= c;
        value <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        board.note_command(kind, r, c, v);
    endtask

    task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        board.write_register(idx, data);
    endtask

    task automatic load_settings(input logic [SIZE_W-1:0] size,
                                 input logic [COUNT_W-1:0] count);
        logic [CFG_DATA_W-1:0] word;
        // junk above the size field must be dropped
        word = CFG_DATA_W'($urandom);
        word[SIZE_W-1:0] = size;
        put_register(CFG_MATRIX_SIZE, word);
        put_register(CFG_SHIFT_COUNT, count);
        if ($urandom_range(0, 1) == 0)
            put_register(CFG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        start <= 1'b0;
        while (board.pending_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic issue_random(output bit counted);
        int unsigned             n;
        int unsigned             pick;
        logic [ROW_W-1:0]        r;
        logic [ROW_W-1:0]        c;
        logic signed [VAL_W-1:0] v;
        bit                      found;
        n       = board.span();
        pick    = $urandom_range(0, 99);
        r       = ROW_W'($urandom_range(0, DIM - 1));
        c       = ROW_W'($urandom_range(0, DIM - 1));
        counted = 1'b1;
        case ($urandom_range(0, 7))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7FFF_FFFF;
            2: v = -1;
            3: v = '0;
            default: v = VAL_W'($urandom);
        endcase
        if (pick < 4)
        begin
            issue(OP_SPARE, r, c, v);
            counted = 1'b0;
        end
        else if (pick < 18)
            issue(OP_SHIFT, r, c, v);
        else if (pick < 58)
        begin
            if (n > 0 && (n == DIM || $urandom_range(0, 9) != 0))
            begin
                r = ROW_W'($urandom_range(0, n - 1));
                c = ROW_W'($urandom_range(0, n - 1));
            end
            issue(OP_WRITE, r, c, v);
        end
        else
        begin
            found = 1'b0;
            if (n > 0 && (n == DIM || $urandom_range(0, 7) != 0))
            begin
                for (int t = 0; t < 16 && !found; t++)
                begin
                    r = ROW_W'($urandom_range(0, n - 1));
                    c = ROW_W'($urandom_range(0, n - 1));
                    found = board.readable(r, c);
                end
            end
            if (!found && n < DIM)
            begin
                // outside the active block: reads back zero
                if ($urandom_range(0, 1) == 0)
                    r = ROW_W'($urandom_range(n, DIM - 1));
                else
                    c = ROW_W'($urandom_range(n, DIM - 1));
                found = 1'b1;
            end
            if (found)
                issue(OP_READ, r, c, v);
            else
                issue(OP_WRITE, r, c, v);
        end
    endtask

    initial
    begin
        int unsigned        issued;
        int unsigned        gap_odds;
        logic [SIZE_W-1:0]  size;
        logic [COUNT_W-1:0] count;
        bit                 counted;
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners and extremes under the reset settings
        issue(OP_WRITE, 4'd0, 4'd0, 32'sh8000_0000);
        issue(OP_WRITE, 4'd15, 4'd15, 32'sh7FFF_FFFF);
        issue(OP_WRITE, 4'd0, 4'd15, -1);
        issue(OP_WRITE, 4'd15, 4'd0, '0);
        issue(OP_WRITE, 4'd10, 4'd5, 32'sh5A5A_A5A5);
        issue(OP_READ, 4'd0, 4'd0, '0);
        issue(OP_READ, 4'd15, 4'd15, -1);
        issue(OP_READ, 4'd0, 4'd15, '0);
        issue(OP_READ, 4'd15, 4'd0, '0);
        issue(OP_READ, 4'd10, 4'd5, '0);
        issue(OP_SPARE, 4'd15, 4'd15, -1);
        issue(OP_SHIFT, 4'd0, 4'd0, '0);
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                if (board.readable(r, c))
                    issue(OP_READ, ROW_W'(r), ROW_W'(c), '0);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0: begin size = 5'd16; count = 16'hFFFF; end
                1: begin size = 5'd1;  count = COUNT_W'($urandom); end
                2: begin size = 5'd2;  count = 16'd1; end
                3: begin size = 5'd0;  count = COUNT_W'($urandom_range(1, 65535)); end
                4: begin size = 5'd31; count = 16'd0; end
                5: begin size = 5'd17; count = COUNT_W'($urandom); end
                // rotation amount of zero
                6: begin size = 5'd16; count = 16'd32; end
                7: begin size = 5'd7;  count = 16'd1; end
                default:
                begin
                    size  = SIZE_W'($urandom_range(1, DIM));
                    count = COUNT_W'($urandom);
                end
            endcase
            load_settings(size, count);
            gap_odds = (phase >= PHASES - 2) ? 0 : $urandom_range(0, 4);
            issued = 0;
            while (issued < PHASE_ITEMS)
            begin
                issue_random(counted);
                if (counted)
                    issued++;
                if (issued < PHASE_ITEMS && $urandom_range(0, 7) < gap_odds)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(posedge clk);
                end
            end
        end

        settle();
        if (board.mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
